// ===== rtl/core/mvsm_pkg.sv =====
package mvsm_pkg;

  localparam int NUM_VOICES_DEF   = 8;
  localparam int NUM_SOUNDS_DEF   = 32;
  localparam int SAMPLE_MEM_DEPTH = 65536;
  localparam int SMP_ADDR_W       = $clog2(SAMPLE_MEM_DEPTH);

  localparam logic [16:0] MAX_LENGTH = 17'h10000;
  localparam logic [8:0]  TAG_ALL    = 9'h1FF;
  localparam logic [7:0]  SILENCE    = 8'd128;
  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam int          MIX_HI     = 127;
  localparam int          MIX_LO     = -127;

  typedef enum logic [2:0] {
    KIND_WRITE  = 3'd0,
    KIND_DEFINE = 3'd1,
    KIND_PLAY   = 3'd2,
    KIND_LOOP   = 3'd3,
    KIND_STOP   = 3'd4,
    KIND_TICK   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_VOICE   = 2'd1,
    ST_NOT_LOADED = 2'd2,
    ST_IGNORED    = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] start;
    logic [16:0] length;
  } sound_entry_t;

endpackage

// ===== rtl/core/multi_voice_sample_mixer.sv =====
// Channel  Handshake          Payload
// in       in_valid/in_stall  kind, sound_index, sample_address, sample_length,
//                             sample_byte, request_id
// out      out_valid/out_stall mixed_sample, sample_valid, status, active_voices
// cfg      cfg_we             cfg_wdata (accept_requests)
//
// One beat at a time; in_stall stays high from acceptance until the result is loaded.
// Write, define, ignored, not-loaded requests go straight to the result; play/loop walks
// voices to the first free one, stop walks all. Tick scans every voice, takes sounding
// ones through position and accumulate, then saturates; one walker, registered memories.
// Reset (rst_n low, synchronous) clears voices, loaded flags and handshake; sample memory
// is not cleared. A stalled result holds; the next beat is taken meanwhile.
module multi_voice_sample_mixer #(
  parameter int NUM_VOICES = mvsm_pkg::NUM_VOICES_DEF,
  parameter int NUM_SOUNDS = mvsm_pkg::NUM_SOUNDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_kind,
  input  logic [4:0]        in_sound_index,
  input  logic [15:0]       in_sample_address,
  input  logic [16:0]       in_sample_length,
  input  logic [7:0]        in_sample_byte,
  input  logic signed [8:0] in_request_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_mixed_sample,
  output logic              out_sample_valid,
  output logic [1:0]        out_status,
  output logic [3:0]        out_active_voices
);

  localparam int VID_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SID_W = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
  localparam int ACT_W = $clog2(NUM_VOICES + 1);
  localparam int SUM_W = $clog2(NUM_VOICES + 1) + 9;
  localparam int AW    = mvsm_pkg::SMP_ADDR_W;
  localparam logic [VID_W-1:0]        LAST_VOICE = VID_W'(NUM_VOICES - 1);
  localparam logic signed [SUM_W-1:0] SUM_HI     = SUM_W'(mvsm_pkg::MIX_HI);
  localparam logic signed [SUM_W-1:0] SUM_LO     = SUM_W'(mvsm_pkg::MIX_LO);
  localparam logic signed [SUM_W-1:0] SUM_MID    = SUM_W'(mvsm_pkg::SILENCE);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_START,
    S_STOP,
    S_TK_SCAN,
    S_TK_POS,
    S_TK_ACC,
    S_TK_SAT,
    S_DONE
  } state_t;

  state_t                   state_r;
  logic                     accept_r;
  logic [2:0]               kind_r;
  logic [SID_W-1:0]         snd_r;
  logic                     snd_ok_r;
  logic [15:0]              addr_r;
  logic [16:0]              len_r;
  logic [7:0]               byte_r;
  logic [8:0]               tag_r;
  logic [VID_W-1:0]         vidx_r;
  logic [NUM_VOICES-1:0]    voice_active_r;
  logic [NUM_VOICES-1:0]    voice_looping_r;
  logic [SID_W-1:0]         voice_sound_r [NUM_VOICES];
  logic [8:0]               voice_tag_r   [NUM_VOICES];
  logic [16:0]              voice_pos_r   [NUM_VOICES];
  logic [NUM_SOUNDS-1:0]    sound_loaded_r;
  logic [ACT_W-1:0]         act_cnt_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [16:0]              cur_pos_r;
  logic [1:0]               res_status_r;
  logic [7:0]               res_mixed_r;
  logic                     res_valid_r;
  logic                     out_valid_r;
  logic [7:0]               out_mixed_r;
  logic                     out_sv_r;
  logic [1:0]               out_status_r;
  logic [3:0]               out_act_r;

  mvsm_pkg::sound_entry_t   sound_mem [NUM_SOUNDS];
  mvsm_pkg::sound_entry_t   snd_rd_r;
  logic [7:0]               sample_mem [mvsm_pkg::SAMPLE_MEM_DEPTH];
  logic [7:0]               smp_rd_r;

  logic                     snd_we;
  logic                     smp_we;
  logic [SID_W-1:0]         cur_sid;
  logic                     last_v;
  logic [16:0]              pos_now;
  logic                     past_end;
  logic [16:0]              pos_cur;
  logic [AW-1:0]            smp_raddr;
  logic [16:0]              pos_nxt;
  logic                     at_end;
  logic signed [9:0]        smp_delta;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [7:0]               mixed_nxt;
  logic                     tag_hit;
  logic                     res_load;

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_mixed_sample  = out_mixed_r;
  assign out_sample_valid  = out_sv_r;
  assign out_status        = out_status_r;
  assign out_active_voices = out_act_r;

  always_comb begin
    snd_we    = (state_r == S_DISPATCH) && (kind_r == mvsm_pkg::KIND_DEFINE) && snd_ok_r;
    smp_we    = (state_r == S_DISPATCH) && (kind_r == mvsm_pkg::KIND_WRITE);
    res_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
    cur_sid   = voice_sound_r[vidx_r];
    last_v    = (vidx_r == LAST_VOICE);
    pos_now   = voice_pos_r[vidx_r];
    past_end  = (pos_now >= snd_rd_r.length);
    pos_cur   = past_end ? 17'd0 : pos_now;
    smp_raddr = AW'({1'b0, snd_rd_r.start} + pos_cur);
    pos_nxt   = cur_pos_r + 17'd1;
    at_end    = (pos_nxt >= snd_rd_r.length);
    smp_delta = $signed({2'b00, smp_rd_r}) - $signed({2'b00, mvsm_pkg::SILENCE});
    sum_nxt   = sum_r + SUM_W'(smp_delta);
    tag_hit   = (tag_r == mvsm_pkg::TAG_ALL) || (voice_tag_r[vidx_r] == tag_r);
    if (sum_r > SUM_HI) begin
      mixed_nxt = mvsm_pkg::FULL_SCALE;
    end else if (sum_r < SUM_LO) begin
      mixed_nxt = 8'd0;
    end else begin
      mixed_nxt = 8'(sum_r + SUM_MID);
    end
  end

  always_ff @(posedge clk) begin
    if (snd_we) begin
      sound_mem[snd_r] <= '{start: addr_r, length: len_r};
    end
    snd_rd_r <= sound_mem[cur_sid];
  end

  always_ff @(posedge clk) begin
    if (smp_we) begin
      sample_mem[addr_r[AW-1:0]] <= byte_r;
    end
    smp_rd_r <= sample_mem[smp_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      accept_r        <= 1'b1;
      voice_active_r  <= '0;
      voice_looping_r <= '0;
      sound_loaded_r  <= '0;
      act_cnt_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        accept_r <= cfg_wdata;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r   <= in_kind;
            snd_r    <= SID_W'(in_sound_index);
            snd_ok_r <= (int'(in_sound_index) < NUM_SOUNDS);
            addr_r   <= in_sample_address;
            len_r    <= (in_sample_length > mvsm_pkg::MAX_LENGTH) ?
                        mvsm_pkg::MAX_LENGTH : in_sample_length;
            byte_r   <= in_sample_byte;
            tag_r    <= in_request_id;
            state_r  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_valid_r <= (kind_r == mvsm_pkg::KIND_TICK);
          res_mixed_r <= 8'd0;
          vidx_r      <= '0;
          sum_r       <= '0;
          unique case (kind_r) inside
            mvsm_pkg::KIND_WRITE: begin
              res_status_r <= mvsm_pkg::ST_OK;
              state_r      <= S_DONE;
            end
            mvsm_pkg::KIND_DEFINE: begin
              state_r <= S_DONE;
              if (snd_ok_r) begin
                sound_loaded_r[snd_r] <= (len_r != 17'd0);
                res_status_r          <= mvsm_pkg::ST_OK;
              end else begin
                res_status_r <= mvsm_pkg::ST_IGNORED;
              end
            end
            mvsm_pkg::KIND_PLAY, mvsm_pkg::KIND_LOOP: begin
              if (!accept_r) begin
                res_status_r <= mvsm_pkg::ST_IGNORED;
                state_r      <= S_DONE;
              end else if (!snd_ok_r || !sound_loaded_r[snd_r]) begin
                res_status_r <= mvsm_pkg::ST_NOT_LOADED;
                state_r      <= S_DONE;
              end else begin
                res_status_r <= mvsm_pkg::ST_OK;
                state_r      <= S_START;
              end
            end
            mvsm_pkg::KIND_STOP: begin
              if (!accept_r) begin
                res_status_r <= mvsm_pkg::ST_IGNORED;
                state_r      <= S_DONE;
              end else begin
                res_status_r <= mvsm_pkg::ST_OK;
                state_r      <= S_STOP;
              end
            end
            mvsm_pkg::KIND_TICK: begin
              res_status_r <= mvsm_pkg::ST_OK;
              state_r      <= S_TK_SCAN;
            end
            default: begin
              res_status_r <= mvsm_pkg::ST_IGNORED;
              state_r      <= S_DONE;
            end
          endcase
        end
        S_START: begin
          if (!voice_active_r[vidx_r]) begin
            voice_active_r[vidx_r]  <= 1'b1;
            voice_looping_r[vidx_r] <= (kind_r == mvsm_pkg::KIND_LOOP);
            voice_sound_r[vidx_r]   <= snd_r;
            voice_tag_r[vidx_r]     <= tag_r;
            voice_pos_r[vidx_r]     <= 17'd0;
            act_cnt_r               <= act_cnt_r + 1'b1;
            state_r                 <= S_DONE;
          end else if (last_v) begin
            res_status_r <= mvsm_pkg::ST_NO_VOICE;
            state_r      <= S_DONE;
          end else begin
            vidx_r <= vidx_r + 1'b1;
          end
        end
        S_STOP: begin
          if (voice_active_r[vidx_r] && tag_hit) begin
            voice_active_r[vidx_r] <= 1'b0;
            act_cnt_r              <= act_cnt_r - 1'b1;
          end
          if (last_v) begin
            state_r <= S_DONE;
          end else begin
            vidx_r <= vidx_r + 1'b1;
          end
        end
        S_TK_SCAN: begin
          if (voice_active_r[vidx_r]) begin
            state_r <= S_TK_POS;
          end else if (last_v) begin
            state_r <= S_TK_SAT;
          end else begin
            vidx_r <= vidx_r + 1'b1;
          end
        end
        S_TK_POS: begin
          if (!sound_loaded_r[cur_sid] || (past_end && !voice_looping_r[vidx_r])) begin
            voice_active_r[vidx_r] <= 1'b0;
            act_cnt_r              <= act_cnt_r - 1'b1;
            if (last_v) begin
              state_r <= S_TK_SAT;
            end else begin
              vidx_r  <= vidx_r + 1'b1;
              state_r <= S_TK_SCAN;
            end
          end else begin
            cur_pos_r <= pos_cur;
            state_r   <= S_TK_ACC;
          end
        end
        S_TK_ACC: begin
          sum_r <= sum_nxt;
          if (!at_end) begin
            voice_pos_r[vidx_r] <= pos_nxt;
          end else if (voice_looping_r[vidx_r]) begin
            voice_pos_r[vidx_r] <= 17'd0;
          end else begin
            voice_active_r[vidx_r] <= 1'b0;
            act_cnt_r              <= act_cnt_r - 1'b1;
          end
          if (last_v) begin
            state_r <= S_TK_SAT;
          end else begin
            vidx_r  <= vidx_r + 1'b1;
            state_r <= S_TK_SCAN;
          end
        end
        S_TK_SAT: begin
          res_mixed_r <= mixed_nxt;
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            out_mixed_r  <= res_mixed_r;
            out_sv_r     <= res_valid_r;
            out_status_r <= res_status_r;
            out_act_r    <= 4'(act_cnt_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_count_tracks_voices: assert property (@(posedge clk) disable iff (!rst_n)
    int'(act_cnt_r) == $countones(voice_active_r))
    else $error("active count out of step with voice flags");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the completion state");

  a_tick_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sv_r |-> out_status_r == mvsm_pkg::ST_OK)
    else $error("tick result with non-ok status");

  a_non_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_sv_r |-> out_mixed_r == 8'd0)
    else $error("non-tick result carries a sample");

endmodule

// ===== bench/multi_voice_sample_mixer_test.sv =====
module multi_voice_sample_mixer_test;

  localparam int VOICES = mvsm_pkg::NUM_VOICES_DEF;
  localparam int SOUNDS = mvsm_pkg::NUM_SOUNDS_DEF;
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]        kind;
    logic [4:0]        sound_index;
    logic [15:0]       sample_address;
    logic [16:0]       sample_length;
    logic [7:0]        sample_byte;
    logic signed [8:0] request_id;
  } mix_req_t;

  typedef struct packed {
    logic [7:0]        mixed_sample;
    logic              sample_valid;
    mvsm_pkg::status_t status;
    logic [3:0]        active_voices;
  } mix_res_t;

  typedef struct packed {
    mix_req_t req;
    logic     typed;
    mix_res_t res;
  } opening_row_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_kind = '0;
  logic [4:0]        in_sound_index = '0;
  logic [15:0]       in_sample_address = '0;
  logic [16:0]       in_sample_length = '0;
  logic [7:0]        in_sample_byte = '0;
  logic signed [8:0] in_request_id = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_mixed_sample;
  logic              out_sample_valid;
  logic [1:0]        out_status;
  logic [3:0]        out_active_voices;

  bit [7:0]  sample_mem [mvsm_pkg::SAMPLE_MEM_DEPTH];
  bit        sample_seen [mvsm_pkg::SAMPLE_MEM_DEPTH];
  bit [15:0] snd_start [SOUNDS];
  bit [16:0] snd_len [SOUNDS];
  bit        snd_loaded [SOUNDS];
  bit        vc_active [VOICES];
  bit        vc_loop [VOICES];
  bit [4:0]  vc_sound [VOICES];
  bit [8:0]  vc_tag [VOICES];
  bit [16:0] vc_pos [VOICES];
  bit        accept_en = 1'b1;

  mix_res_t     owed [$];
  opening_row_t opening_rows [$];
  int           errors = 0;
  int           pending_gap = 1;
  bit           tx_burst = 1'b0;
  int           hold_asks = 0;

  multi_voice_sample_mixer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_sound_index    (in_sound_index),
    .in_sample_address (in_sample_address),
    .in_sample_length  (in_sample_length),
    .in_sample_byte    (in_sample_byte),
    .in_request_id     (in_request_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mixed_sample  (out_mixed_sample),
    .out_sample_valid  (out_sample_valid),
    .out_status        (out_status),
    .out_active_voices (out_active_voices)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic mix_res_t advance_mixer(input mix_req_t r);
    mix_res_t  res;
    bit [16:0] ln;
    bit [16:0] tap;
    bit [4:0]  s;
    int        sum;
    int        v;
    int        n;
    res = '0;
    res.status = mvsm_pkg::ST_OK;
    case (r.kind)
      mvsm_pkg::KIND_WRITE: begin
        sample_mem[r.sample_address] = r.sample_byte;
        sample_seen[r.sample_address] = 1'b1;
      end
      mvsm_pkg::KIND_DEFINE: begin
        ln = (r.sample_length > mvsm_pkg::MAX_LENGTH) ? mvsm_pkg::MAX_LENGTH :
             r.sample_length;
        snd_start[r.sound_index] = r.sample_address;
        snd_len[r.sound_index] = ln;
        snd_loaded[r.sound_index] = (ln != 0);
      end
      mvsm_pkg::KIND_PLAY, mvsm_pkg::KIND_LOOP: begin
        if (!accept_en) begin
          res.status = mvsm_pkg::ST_IGNORED;
        end else if (!snd_loaded[r.sound_index]) begin
          res.status = mvsm_pkg::ST_NOT_LOADED;
        end else begin
          res.status = mvsm_pkg::ST_NO_VOICE;
          for (v = 0; v < VOICES; v++) begin
            if (!vc_active[v]) begin
              vc_active[v] = 1'b1;
              vc_loop[v] = (r.kind == mvsm_pkg::KIND_LOOP);
              vc_sound[v] = r.sound_index;
              vc_tag[v] = r.request_id;
              vc_pos[v] = '0;
              res.status = mvsm_pkg::ST_OK;
              break;
            end
          end
        end
      end
      mvsm_pkg::KIND_STOP: begin
        if (!accept_en) begin
          res.status = mvsm_pkg::ST_IGNORED;
        end else begin
          for (v = 0; v < VOICES; v++)
            if (vc_active[v] &&
                (r.request_id == mvsm_pkg::TAG_ALL || vc_tag[v] == r.request_id))
              vc_active[v] = 1'b0;
        end
      end
      mvsm_pkg::KIND_TICK: begin
        sum = 0;
        for (v = 0; v < VOICES; v++) begin
          if (!vc_active[v]) continue;
          s = vc_sound[v];
          if (!snd_loaded[s]) begin
            vc_active[v] = 1'b0;
            continue;
          end
          if (vc_pos[v] >= snd_len[s]) begin
            if (!vc_loop[v]) begin
              vc_active[v] = 1'b0;
              continue;
            end
            vc_pos[v] = '0;
          end
          tap = snd_start[s] + vc_pos[v];
          sum += int'(sample_mem[tap[15:0]]) - int'(mvsm_pkg::SILENCE);
          vc_pos[v]++;
          if (vc_pos[v] >= snd_len[s]) begin
            if (vc_loop[v]) vc_pos[v] = '0;
            else vc_active[v] = 1'b0;
          end
        end
        if (sum > mvsm_pkg::MIX_HI) res.mixed_sample = mvsm_pkg::FULL_SCALE;
        else if (sum < mvsm_pkg::MIX_LO) res.mixed_sample = 8'd0;
        else res.mixed_sample = 8'(sum + int'(mvsm_pkg::SILENCE));
        res.sample_valid = 1'b1;
      end
      default: res.status = mvsm_pkg::ST_IGNORED;
    endcase
    n = 0;
    for (v = 0; v < VOICES; v++)
      if (vc_active[v]) n++;
    res.active_voices = 4'(n);
    return res;
  endfunction

  function automatic int unwritten_tap();
    bit [16:0] pos;
    bit [16:0] tap;
    bit [4:0]  s;
    int        v;
    for (v = 0; v < VOICES; v++) begin
      s = vc_sound[v];
      if (!vc_active[v] || !snd_loaded[s]) continue;
      pos = vc_pos[v];
      if (pos >= snd_len[s]) begin
        if (!vc_loop[v]) continue;
        pos = '0;
      end
      tap = snd_start[s] + pos;
      if (!sample_seen[tap[15:0]]) return int'(tap[15:0]);
    end
    return -1;
  endfunction

  function automatic mix_req_t draw_request();
    mix_req_t r;
    int       pick;
    int       sub;
    int       j;
    int       miss;
    r.kind = 3'($urandom);
    r.sound_index = 5'($urandom);
    r.sample_address = 16'($urandom);
    r.sample_length = 17'($urandom);
    r.sample_byte = 8'($urandom);
    r.request_id = 9'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 32) begin
      r.kind = mvsm_pkg::KIND_TICK;
    end else if (pick < 54) begin
      r.kind = (pick < 44) ? mvsm_pkg::KIND_LOOP : mvsm_pkg::KIND_PLAY;
      if ($urandom_range(0, 3) != 0) r.sound_index = 5'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: r.request_id = mvsm_pkg::TAG_ALL;
        1: r.request_id = 9'($urandom_range(0, 3));
        2: r.request_id = 9'd255;
        default: ;
      endcase
    end else if (pick < 62) begin
      r.kind = mvsm_pkg::KIND_STOP;
      sub = $urandom_range(0, 9);
      if (sub < 5) r.request_id = vc_tag[$urandom_range(0, VOICES - 1)];
      else if (sub < 7) r.request_id = mvsm_pkg::TAG_ALL;
      else if (sub < 8) r.request_id = 9'($urandom_range(0, 3));
    end else if (pick < 74) begin
      r.kind = mvsm_pkg::KIND_DEFINE;
      if ($urandom_range(0, 3) != 0) r.sound_index = 5'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) r.sample_address = 16'hFFF8 + 16'($urandom_range(0, 7));
      sub = $urandom_range(0, 19);
      if (sub < 11) r.sample_length = 17'($urandom_range(1, 6));
      else if (sub < 14) r.sample_length = '0;
      else if (sub < 16) r.sample_length = 17'($urandom_range(17'h10000, 17'h1FFFF));
      else r.sample_length = 17'($urandom_range(7, 40));
    end else if (pick < 97) begin
      r.kind = mvsm_pkg::KIND_WRITE;
      if ($urandom_range(0, 4) < 3) begin
        j = $urandom_range(0, 7);
        r.sample_address = snd_start[j] + 16'($urandom_range(0, 15));
      end
    end else begin
      r.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_HI : KIND_SPARE_LO;
    end
    // replace the tick with a write of the first unwritten byte it would read
    if (r.kind == mvsm_pkg::KIND_TICK) begin
      miss = unwritten_tap();
      if (miss >= 0) begin
        r.kind = mvsm_pkg::KIND_WRITE;
        r.sample_address = 16'(miss);
      end
    end
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] k, input logic [4:0] snd,
                                  input logic [15:0] addr, input logic [16:0] len,
                                  input logic [7:0] smp, input logic signed [8:0] id,
                                  input logic typed, input logic [7:0] mixed,
                                  input logic sv, input mvsm_pkg::status_t st,
                                  input logic [3:0] act);
    opening_row_t row;
    row.req = '{k, snd, addr, len, smp, id};
    row.typed = typed;
    row.res.mixed_sample = mixed;
    row.res.sample_valid = sv;
    row.res.status = st;
    row.res.active_voices = act;
    opening_rows.push_back(row);
  endfunction

  task automatic send_beat(input mix_req_t req, input bit typed, input mix_res_t typed_res,
                           input bit last, output mix_res_t predicted);
    if (pending_gap != 0) repeat (pending_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_kind <= req.kind;
    in_sound_index <= req.sound_index;
    in_sample_address <= req.sample_address;
    in_sample_length <= req.sample_length;
    in_sample_byte <= req.sample_byte;
    in_request_id <= req.request_id;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predicted = advance_mixer(req);
    owed.push_back(typed ? typed_res : predicted);
    pending_gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (last && pending_gap == 0) pending_gap = 1;
    if (pending_gap != 0) in_valid <= 1'b0;
  endtask

  task automatic settle();
    while (owed.size() != 0) @(posedge clk);
  endtask

  task automatic set_accept(input logic en);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we <= 1'b0;
    accept_en = en;
  endtask

  task automatic play_random_mix(input int beats, input int hold_at);
    mix_req_t req;
    mix_res_t got;
    int       n;
    n = 0;
    while (n < beats) begin
      if (n % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if (n == hold_at) hold_asks++;
      req = draw_request();
      send_beat(req, 1'b0, '0, n == beats - 1, got);
      n++;
    end
  endtask

  initial begin
    mix_res_t want;
    int       stall_left;
    int       beats_out;
    int       hold_seen;
    bit       rx_burst;
    stall_left = 0;
    beats_out = 0;
    hold_seen = 0;
    rx_burst = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (owed.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = owed.pop_front();
          if (out_mixed_sample !== want.mixed_sample) begin
            $error("mixed_sample: expected %0d, got %0d", want.mixed_sample, out_mixed_sample);
            errors++;
          end
          if (out_sample_valid !== want.sample_valid) begin
            $error("sample_valid: expected %0d, got %0d", want.sample_valid, out_sample_valid);
            errors++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_active_voices !== want.active_voices) begin
            $error("active_voices: expected %0d, got %0d", want.active_voices,
                   out_active_voices);
            errors++;
          end
        end
        beats_out++;
        if (beats_out % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        stall_left = rx_burst ? 0 : $urandom_range(0, 5);
      end
      // hold off long enough to back up the input
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        stall_left = 120;
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    mix_res_t got;
    int       i;
    add_row(mvsm_pkg::KIND_TICK, 0, 16'h0000, 0, 0, 0, 1, 8'd128, 1, mvsm_pkg::ST_OK, 0);
    add_row(mvsm_pkg::KIND_STOP, 0, 16'h0000, 0, 0, -1, 1, 0, 0, mvsm_pkg::ST_OK, 0);
    add_row(mvsm_pkg::KIND_PLAY, 0, 16'h0000, 0, 0, 0, 1, 0, 0, mvsm_pkg::ST_NOT_LOADED, 0);
    add_row(KIND_SPARE_LO, 0, 16'h0000, 0, 0, 0, 1, 0, 0, mvsm_pkg::ST_IGNORED, 0);
    add_row(mvsm_pkg::KIND_WRITE, 0, 16'hFFFF, 0, 8'd255, 0, 0, 0, 0, mvsm_pkg::ST_OK, 0);
    add_row(mvsm_pkg::KIND_WRITE, 0, 16'h0000, 0, 8'd0, 0, 0, 0, 0, mvsm_pkg::ST_OK, 0);
    add_row(mvsm_pkg::KIND_WRITE, 0, 16'h0001, 0, 8'd128, 0, 0, 0, 0, mvsm_pkg::ST_OK, 0);
    add_row(mvsm_pkg::KIND_DEFINE, 31, 16'hFFFF, 17'h1FFFF, 0, 0, 0, 0, 0,
            mvsm_pkg::ST_OK, 0);
    add_row(mvsm_pkg::KIND_DEFINE, 0, 16'hFFFF, 17'd2, 0, 0, 0, 0, 0, mvsm_pkg::ST_OK, 0);
    add_row(mvsm_pkg::KIND_DEFINE, 1, 16'h0000, 17'd0, 0, 0, 0, 0, 0, mvsm_pkg::ST_OK, 0);
    add_row(mvsm_pkg::KIND_PLAY, 1, 16'h0000, 0, 0, 0, 1, 0, 0, mvsm_pkg::ST_NOT_LOADED, 0);
    add_row(mvsm_pkg::KIND_LOOP, 0, 16'h0000, 0, 0, 255, 0, 0, 0, mvsm_pkg::ST_OK, 0);
    add_row(mvsm_pkg::KIND_PLAY, 31, 16'h0000, 0, 0, -1, 0, 0, 0, mvsm_pkg::ST_OK, 0);
    add_row(mvsm_pkg::KIND_TICK, 0, 16'h0000, 0, 0, 0, 1, 8'd255, 1, mvsm_pkg::ST_OK, 2);
    add_row(mvsm_pkg::KIND_TICK, 0, 16'h0000, 0, 0, 0, 1, 8'd0, 1, mvsm_pkg::ST_OK, 2);
    add_row(mvsm_pkg::KIND_STOP, 0, 16'h0000, 0, 0, 255, 0, 0, 0, mvsm_pkg::ST_OK, 0);
    for (i = 0; i < VOICES - 1; i++)
      add_row(mvsm_pkg::KIND_LOOP, 0, 16'h0000, 0, 0, 9'(i + 1), 0, 0, 0,
              mvsm_pkg::ST_OK, 0);
    add_row(mvsm_pkg::KIND_PLAY, 0, 16'h0000, 0, 0, 0, 1, 0, 0, mvsm_pkg::ST_NO_VOICE, 8);
    add_row(mvsm_pkg::KIND_DEFINE, 0, 16'h0000, 17'd0, 0, 0, 0, 0, 0, mvsm_pkg::ST_OK, 0);
    add_row(mvsm_pkg::KIND_TICK, 0, 16'h0000, 0, 0, 0, 1, 8'd128, 1, mvsm_pkg::ST_OK, 1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_accept(1'b1);
    for (i = 0; i < opening_rows.size(); i++)
      send_beat(opening_rows[i].req, opening_rows[i].typed, opening_rows[i].res,
                i == opening_rows.size() - 1, got);

    set_accept(1'b0);
    play_random_mix(40, -1);
    set_accept(1'b1);
    play_random_mix(300, 100);
    set_accept(1'b0);
    play_random_mix(20, -1);
    set_accept(1'b1);
    play_random_mix(300, -1);

    settle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
